>>> design/fcfm_pkg.sv
package fcfm_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam int THR_W  = 15;
    localparam int CTR_W  = 32;
    localparam int DEV_W  = 30;
    localparam int GAIN_W = 4;
    localparam int VOL_W  = 15;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_THRESHOLD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_INCREMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_VOLUME    = 3'd4;

    localparam logic [THR_W-1:0]  CLIP_THRESHOLD_RST   = 15'd13926;
    localparam logic [CTR_W-1:0]  CENTER_INCREMENT_RST = 32'd1498764629;
    localparam logic [DEV_W-1:0]  DEVIATION_SCALE_RST  = 30'd134217728;
    localparam logic [GAIN_W-1:0] FILTER_GAIN_RST      = 4'd6;
    localparam logic [VOL_W-1:0]  OUTPUT_VOLUME_RST    = 15'd983;

    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned PI_Q30      = 64'd3373259426;

    localparam longint CUTOFF_HZ     = 64'sd8000;
    localparam longint RATE_HZ       = 64'sd192000;
    localparam longint TWO_RATE_HZ   = 2 * RATE_HZ;
    localparam longint unsigned TWO_RATE_U = 64'd384000;
    localparam longint LP_CENTER_Q30 = (2 * CUTOFF_HZ * 64'sd1073741824) / RATE_HZ;

    typedef struct packed {
        logic busy;
        logic done;
    } fir_status_t;

    // shift-subtract divide, elaboration only
    function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = 64'd0;
        r = 64'd0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sine of a fraction of a turn, Q30, Taylor series per quadrant
    function automatic longint sine_q30(logic [31:0] turn);
        logic [1:0] quad;
        longint unsigned u;
        longint unsigned x;
        longint unsigned term;
        longint unsigned mag;
        longint sum;
        quad = turn[31:30];
        u    = {34'd0, turn[29:0]};
        if (quad[0])
            u = ONE_Q30 - u;
        x    = (u * HALF_PI_Q30) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                6:       term = term / 156;
                default: term = term / 210;
            endcase
            if ((k & 1) != 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        mag = (sum < 0) ? 64'd0 : $unsigned(sum);
        return (quad >= 2'd2) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sine_entry(int i, int bits);
        longint s;
        longint unsigned m;
        longint unsigned v;
        logic [31:0] turn;
        turn = 32'(i) << (32 - bits);
        s    = sine_q30(turn);
        m    = $unsigned((s < 0) ? -s : s);
        v    = (m * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return (s < 0) ? SAMPLE_W'(-$signed(v)) : SAMPLE_W'(v);
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_entry(int i, int taps, int phases);
        longint total;
        longint mi;
        longint d;
        longint n;
        longint rd;
        longint lp;
        longint sv;
        longint cw;
        longint win;
        longint r;
        longint unsigned sm;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned c;
        logic [31:0] turn;
        logic neg;
        total = longint'(taps) * longint'(phases);
        mi    = longint'(i) * longint'(phases) + 1;
        d     = 2 * mi - total - 1;
        if (d == 0)
            lp = LP_CENTER_Q30;
        else
        begin
            n = (d * CUTOFF_HZ) % TWO_RATE_HZ;
            if (n < 0)
                n = n + TWO_RATE_HZ;
            turn = 32'(($unsigned(n) << 32) / TWO_RATE_U);
            sv   = sine_q30(turn);
            sm   = $unsigned((sv < 0) ? -sv : sv);
            den  = $unsigned((d < 0) ? -d : d) * PI_Q30;
            lp   = $signed(udiv64(sm << 31, den));
            if ((sv < 0) != (d < 0))
                lp = -lp;
        end
        rd   = (mi >= total) ? mi - total : mi;
        turn = 32'(udiv64($unsigned(rd) << 32, $unsigned(total)) + 64'h4000_0000);
        cw   = sine_q30(turn);
        win  = (54 * $signed(ONE_Q30) - 46 * cw) / 100;
        neg  = (lp < 0);
        mag  = $unsigned(neg ? -lp : lp);
        c    = (mag * $unsigned(win) + (64'd1 << 40)) >> 41;
        if (neg)
            r = (c > 64'd131072) ? -64'sd131072 : -$signed(c);
        else
            r = (c > 64'd131071) ? 64'sd131071 : $signed(c);
        return COEF_W'(r);
    endfunction

endpackage

>>> design/fcfm_fir.sv
module fcfm_fir
    import fcfm_pkg::*;
#(
    parameter int TAP_COUNT   = 32,
    parameter int PHASE_COUNT = 32
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         load,
    input  logic signed [SAMPLE_W-1:0]                   sample,
    output fir_status_t                                  status,
    output logic signed [PROD_W+$clog2(TAP_COUNT)-1:0]   acc
);

    localparam int ACC_W     = PROD_W + $clog2(TAP_COUNT);
    localparam int TAP_IDX_W = $clog2(TAP_COUNT);
    localparam int CNT_W     = $clog2(TAP_COUNT + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TAP_COUNT);

    logic signed [COEF_W-1:0]   coef_rom [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] line_reg [TAP_COUNT];
    logic signed [SAMPLE_W-1:0] shift_in;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [TAP_IDX_W-1:0]       tap_idx;
    logic                       busy_reg;
    logic                       done_reg;
    logic                       rotate;
    logic                       shift_en;

    for (genvar g = 0; g < TAP_COUNT; g++)
    begin : g_coef
        assign coef_rom[g] = coef_entry(g, TAP_COUNT, PHASE_COUNT);
    end

    assign tap_idx   = cnt_reg[TAP_IDX_W-1:0];
    assign rotate    = busy_reg && (cnt_reg != LAST_CNT);
    assign shift_en  = load || rotate;
    assign shift_in  = load ? sample : line_reg[0];
    assign prod_next = coef_rom[tap_idx] * line_reg[0];

    // oldest sample sits at the head; one full rotation restores the order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
                line_reg[i] <= '0;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < TAP_COUNT - 1; i++)
                line_reg[i] <= line_reg[i+1];
            line_reg[TAP_COUNT-1] <= shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (rotate)
                prod_reg <= prod_next;
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign acc         = acc_reg;

endmodule

>>> design/fir_clip_fm_modulator.sv
// FM subcarrier modulator. Each signed Q1.15 audio item on the s_ stream enters a
// TAP_COUNT-deep delay line, is low-pass filtered with a fixed windowed-sinc, scaled by
// filter_gain, clipped to +-clip_threshold and used to set the phase step
// center_increment + clipped * deviation_scale / 2^15. Each item yields one m_ item:
// output_volume times the sine of the phase held before this item's step. The filter
// uses a single multiply-accumulate that walks the rotating delay line one tap per cycle.
// The result sits in an output register, so the next item is accepted while it waits.
// Registers must be written by the user through cfg_we / cfg_index / cfg_data while the
// block is idle; the block itself does not enforce this. Unknown indexes are ignored.
module fir_clip_fm_modulator
    import fcfm_pkg::*;
#(
    parameter int TAP_COUNT       = 32,
    parameter int PHASE_COUNT     = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int PHASE_BITS      = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,    // [15:0] audio_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,    // [15:0] carrier_sample
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int ACC_W      = PROD_W + $clog2(TAP_COUNT);
    localparam int SCALED_W   = ACC_W + GAIN_W + 1;
    localparam int FILT_SHIFT = 19;
    localparam int ROUND_W    = SCALED_W - FILT_SHIFT;
    localparam int DEVP_W     = SAMPLE_W + DEV_W + 1;
    localparam int DELTA_W    = 32;
    localparam int STEP_EXT_W = (PHASE_BITS > DELTA_W) ? PHASE_BITS : DELTA_W;
    localparam int SINE_DEPTH = 2 ** SINE_TABLE_BITS;
    localparam int VOLP_W     = 2 * SAMPLE_W;

    localparam logic signed [SCALED_W-1:0] FILT_HALF = SCALED_W'(1) << (FILT_SHIFT - 1);
    localparam logic signed [VOLP_W-1:0]   VOL_HALF  = VOLP_W'(1) << (SAMPLE_W - 2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIR   = 3'd1;
    localparam logic [2:0] ST_GAIN  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_CLIP  = 3'd4;
    localparam logic [2:0] ST_DEV   = 3'd5;
    localparam logic [2:0] ST_STEP  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [THR_W-1:0]  thr_reg;
    logic [CTR_W-1:0]  center_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [VOL_W-1:0]  vol_reg;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    fir_status_t              fir_status;
    logic signed [ACC_W-1:0]  fir_acc;
    logic                     accept;
    logic                     emit;

    logic signed [SCALED_W-1:0] scaled_reg;
    logic signed [SCALED_W-1:0] scaled_sum;
    logic signed [ROUND_W-1:0]  rounded_reg;
    logic signed [SAMPLE_W-1:0] thr_pos;
    logic signed [SAMPLE_W-1:0] thr_neg;
    logic signed [SAMPLE_W-1:0] filt_next;
    logic signed [SAMPLE_W-1:0] filt_reg;
    logic signed [DEVP_W-1:0]   devp;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic [PHASE_BITS-1:0]      step_reg;
    logic [PHASE_BITS-1:0]      step_next;
    logic [PHASE_BITS-1:0]      phase_reg;

    logic signed [SAMPLE_W-1:0] sine_rom [SINE_DEPTH];
    logic signed [SAMPLE_W-1:0] sine_rd_reg;
    logic signed [VOLP_W-1:0]   volp_reg;
    logic signed [VOLP_W-1:0]   volp_sum;
    logic [15:0]                out_data_reg;
    logic                       out_valid_reg;

    for (genvar g = 0; g < SINE_DEPTH; g++)
    begin : g_sine
        assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    fcfm_fir #(
        .TAP_COUNT   (TAP_COUNT),
        .PHASE_COUNT (PHASE_COUNT)
    ) u_fir (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .sample ($signed(s_tdata)),
        .status (fir_status),
        .acc    (fir_acc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= CLIP_THRESHOLD_RST;
            center_reg <= CENTER_INCREMENT_RST;
            dev_reg    <= DEVIATION_SCALE_RST;
            gain_reg   <= FILTER_GAIN_RST;
            vol_reg    <= OUTPUT_VOLUME_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_THRESHOLD:   thr_reg    <= cfg_data[THR_W-1:0];
                REG_CENTER_INCREMENT: center_reg <= cfg_data[CTR_W-1:0];
                REG_DEVIATION_SCALE:  dev_reg    <= cfg_data[DEV_W-1:0];
                REG_FILTER_GAIN:      gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_OUTPUT_VOLUME:    vol_reg    <= cfg_data[VOL_W-1:0];
                default:              ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_FIR;
            ST_FIR:   if (fir_status.done) state_next = ST_GAIN;
            ST_GAIN:  state_next = ST_ROUND;
            ST_ROUND: state_next = ST_CLIP;
            ST_CLIP:  state_next = ST_DEV;
            ST_DEV:   state_next = ST_STEP;
            ST_STEP:  state_next = ST_EMIT;
            ST_EMIT:  if (emit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // filter post-processing: gain, round, clip, deviation, step
    assign scaled_sum = scaled_reg + FILT_HALF;
    assign thr_pos    = $signed({1'b0, thr_reg});
    assign thr_neg    = -thr_pos;
    assign devp       = filt_reg * $signed({1'b0, dev_reg});
    assign step_next  = PHASE_BITS'(STEP_EXT_W'(delta_reg) + STEP_EXT_W'(center_reg));

    always_comb
    begin
        if (rounded_reg > thr_pos)
            filt_next = thr_pos;
        else if (rounded_reg < thr_neg)
            filt_next = thr_neg;
        else
            filt_next = SAMPLE_W'(rounded_reg);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_GAIN:  scaled_reg  <= fir_acc * $signed({1'b0, gain_reg});
            ST_ROUND: rounded_reg <= ROUND_W'(scaled_sum >>> FILT_SHIFT);
            ST_CLIP:  filt_reg    <= filt_next;
            ST_DEV:   delta_reg   <= DELTA_W'(devp >>> (SAMPLE_W - 1));
            ST_STEP:  step_reg    <= step_next;
            default:  ;
        endcase
    end

    // output path follows the current phase continuously
    assign volp_sum = volp_reg + VOL_HALF;

    always_ff @(posedge clk)
    begin
        sine_rd_reg <= sine_rom[phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS]];
        volp_reg    <= $signed({1'b0, vol_reg}) * sine_rd_reg;
        if (emit)
            out_data_reg <= 16'(volp_sum >>> (SAMPLE_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                phase_reg     <= phase_reg + step_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_ready_fir_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !fir_status.busy)
        else $error("input ready while filter busy");

    a_accept_starts_fir: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_FIR) && fir_status.busy)
        else $error("accepted item did not start filter");

    a_done_in_fir: assert property (@(posedge clk) disable iff (!rst_n)
        fir_status.done |-> (state_reg == ST_FIR))
        else $error("filter done outside filter state");

    a_phase_only_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != $past(phase_reg)) |-> ($past(state_reg) == ST_EMIT))
        else $error("phase moved outside emit");

endmodule
